FILE: rtl/core/actuator_run_pause_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// actuator_run_pause_sequencer_core_assert
// assertion macros used by the sequencer control block
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_RUN_PAUSE_SEQUENCER_CORE_ASSERT_SVH
`define ACTUATOR_RUN_PAUSE_SEQUENCER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ARPS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ARPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ARPS_ASSERT(lbl, ante, cons, msg)
`define ARPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/arps_pkg.sv
// ----------------------------------------------------------------------------
// arps_pkg
// types and constants of the run/pause relay sequencer
// ----------------------------------------------------------------------------
package arps_pkg;

	localparam int RELAY_W    = 6;
	localparam int CODE_W     = 8;
	localparam int DUR_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_TIMERS = 4;

	localparam int T_INIT  = 0;
	localparam int T_FWD   = 1;
	localparam int T_BACK  = 2;
	localparam int T_PAUSE = 3;

	localparam logic [RELAY_W-1:0] LINES_FWD  = 6'h15;
	localparam logic [RELAY_W-1:0] LINES_BACK = 6'h2A;

	localparam logic [DUR_W-1:0]  RST_INIT_TICKS  = 16'd1300;
	localparam logic [DUR_W-1:0]  RST_RUN_TICKS   = 16'd1300;
	localparam logic [DUR_W-1:0]  RST_PAUSE_TICKS = 16'd50;
	localparam logic [CODE_W-1:0] RST_FWD_CODE    = 8'h31;
	localparam logic [CODE_W-1:0] RST_BACK_CODE   = 8'h32;

	typedef enum logic [1:0] {
		TM_IDLE,
		TM_RUN,
		TM_HOLD,
		TM_DONE
	} timer_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INIT_TICKS,
		REG_RUN_TICKS,
		REG_PAUSE_DELAY_TICKS,
		REG_FORWARD_CODE,
		REG_BACK_CODE
	} cfg_reg_t;

	typedef struct packed {
		logic               tick;
		logic [CODE_W-1:0]  rx_byte;
		logic               forward_request;
		logic               back_request;
		logic               pause_request;
		logic [RELAY_W-1:0] manual_requests;
	} in_item_t;

	typedef struct packed {
		logic [RELAY_W-1:0] relay_lines;
		logic               ready_res;
		logic               mode_forward;
		logic               mode_back;
		logic               mode_paused;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic hold;
		logic resume;
	} timer_cmd_t;

endpackage

FILE: rtl/core/arps_if.sv
// ----------------------------------------------------------------------------
// arps_if
// valid/ready channels of the sequencer: items, results, register writes
// ----------------------------------------------------------------------------
interface arps_in_if import arps_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arps_out_if import arps_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface arps_cfg_if import arps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/arps_timer.sv
// ----------------------------------------------------------------------------
// arps_timer
// tick timer with start, hold, resume, saturating count and sticky timeout
// ----------------------------------------------------------------------------
module arps_timer import arps_pkg::*; #(
	parameter int          W        = 16,
	parameter timer_mode_t RST_MODE = TM_IDLE
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic         tick,
	input  timer_cmd_t   cmd,
	input  logic [W-1:0] dur,
	output timer_mode_t  mode
);

	localparam logic [W-1:0] ELAPSED_MAX = '1;

	timer_mode_t  mode_q;
	timer_mode_t  mode_d;
	timer_mode_t  mode_start;
	timer_mode_t  mode_sup;
	logic [W-1:0] elapsed_q;
	logic [W-1:0] elapsed_d;
	logic [W-1:0] elapsed_start;

	always_comb begin
		mode_start    = mode_q;
		elapsed_start = elapsed_q;
		if (cmd.start) begin
			mode_start    = TM_RUN;
			elapsed_start = '0;
		end
		mode_sup = mode_start;
		if (cmd.hold && mode_start == TM_RUN) begin
			mode_sup = TM_HOLD;
		end else if (cmd.resume && mode_start == TM_HOLD) begin
			mode_sup = TM_RUN;
		end
		mode_d    = mode_sup;
		elapsed_d = elapsed_start;
		if (tick && mode_sup == TM_RUN) begin
			if (elapsed_start != ELAPSED_MAX) begin
				elapsed_d = elapsed_start + 1'b1;
			end
			if (elapsed_d >= dur) begin
				mode_d = TM_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RST_MODE;
			elapsed_q <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign mode = mode_q;

endmodule

FILE: rtl/core/arps_ctrl.sv
// ----------------------------------------------------------------------------
// arps_ctrl
// request latching, run/pause processing, supervision and relay state
// ----------------------------------------------------------------------------
`include "actuator_run_pause_sequencer_core_assert.svh"

module arps_ctrl import arps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  in_item_t          item,
	input  logic [CODE_W-1:0] forward_code,
	input  logic [CODE_W-1:0] back_code,
	input  timer_mode_t       tmode [NUM_TIMERS],
	output timer_cmd_t        tcmd  [NUM_TIMERS],
	output out_item_t         result
);

	logic               init_q, fa_q, ba_q, ps_q, armed_q;
	logic [2:0]         pend_q;
	logic [RELAY_W-1:0] pman_q, mmem_q, relay_q;

	logic               init_d, fa_d, ba_d, ps_d, armed_d;
	logic [2:0]         pend_d;
	logic [RELAY_W-1:0] pman_d, mmem_d, relay_d;

	logic [2:0]         pend_l;
	logic [RELAY_W-1:0] pman_l, man_bit;
	logic               fwd_ok, back_ok, pause_ok;
	logic               fwd_done, back_done, pause_done;

	always_comb begin
		pend_l  = pend_q | {item.pause_request, item.back_request, item.forward_request};
		pman_l  = pman_q | item.manual_requests;
		man_bit = pman_l & (~pman_l + 1'b1);

		fwd_ok   = init_q && item.rx_byte == forward_code && pend_l[0] && !ps_q && !ba_q;
		back_ok  = init_q && !fwd_ok && item.rx_byte == back_code && pend_l[1]
			&& !ps_q && !fa_q;
		pause_ok = init_q && !fwd_ok && !back_ok && pend_l[2] && tmode[T_PAUSE] != TM_RUN;

		for (int i = 0; i < NUM_TIMERS; i++) begin
			tcmd[i] = '0;
		end

		init_d  = init_q;
		fa_d    = fa_q;
		ba_d    = ba_q;
		ps_d    = ps_q;
		armed_d = armed_q;
		pend_d  = pend_l;
		pman_d  = pman_l;
		mmem_d  = mmem_q;
		relay_d = relay_q;

		// process
		if (fwd_ok) begin
			fa_d              = 1'b1;
			pend_d[0]         = 1'b0;
			relay_d           = relay_d | LINES_FWD;
			tcmd[T_FWD].start = 1'b1;
		end else if (back_ok) begin
			ba_d               = 1'b1;
			pend_d[1]          = 1'b0;
			relay_d            = relay_d | LINES_BACK;
			tcmd[T_BACK].start = 1'b1;
		end else if (pause_ok) begin
			pend_d[2]           = 1'b0;
			armed_d             = 1'b1;
			tcmd[T_PAUSE].start = 1'b1;
		end
		if (init_q) begin
			pman_d  = pman_l & ~man_bit;
			mmem_d  = mmem_q ^ man_bit;
			relay_d = (relay_d & ~man_bit) | (mmem_d & man_bit);
		end

		// supervise
		fwd_done   = tmode[T_FWD] == TM_DONE && !tcmd[T_FWD].start;
		back_done  = tmode[T_BACK] == TM_DONE && !tcmd[T_BACK].start;
		pause_done = tmode[T_PAUSE] == TM_DONE && !tcmd[T_PAUSE].start;
		if (init_q) begin
			if (fwd_done && fa_d) begin
				fa_d    = 1'b0;
				ps_d    = 1'b0;
				relay_d = relay_d & ~LINES_FWD;
			end else if (back_done && ba_d) begin
				ba_d    = 1'b0;
				ps_d    = 1'b0;
				relay_d = relay_d & ~LINES_BACK;
			end else if (pause_done && armed_d) begin
				ps_d    = !ps_d;
				armed_d = 1'b0;
				if (fa_d) begin
					tcmd[T_FWD].hold   = ps_d;
					tcmd[T_FWD].resume = !ps_d;
					relay_d = ps_d ? (relay_d & ~LINES_FWD) : (relay_d | LINES_FWD);
				end else if (ba_d) begin
					tcmd[T_BACK].hold   = ps_d;
					tcmd[T_BACK].resume = !ps_d;
					relay_d = ps_d ? (relay_d & ~LINES_BACK) : (relay_d | LINES_BACK);
				end
			end
		end else if (tmode[T_INIT] == TM_DONE) begin
			init_d  = 1'b1;
			relay_d = relay_d & ~LINES_BACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b0;
			fa_q    <= 1'b0;
			ba_q    <= 1'b0;
			ps_q    <= 1'b0;
			armed_q <= 1'b0;
			pend_q  <= '0;
			pman_q  <= '0;
			mmem_q  <= '0;
			relay_q <= LINES_BACK;
		end else if (step) begin
			init_q  <= init_d;
			fa_q    <= fa_d;
			ba_q    <= ba_d;
			ps_q    <= ps_d;
			armed_q <= armed_d;
			pend_q  <= pend_d;
			pman_q  <= pman_d;
			mmem_q  <= mmem_d;
			relay_q <= relay_d;
		end
	end

	assign result.relay_lines  = relay_d;
	assign result.ready_res    = init_d;
	assign result.mode_forward = fa_d;
	assign result.mode_back    = ba_d;
	assign result.mode_paused  = ps_d;

	`ARPS_ASSERT(a_runs_exclusive, fa_q, !ba_q, "forward and back runs both active")
	`ARPS_ASSERT(a_hold_lines, !init_q, relay_q == LINES_BACK && !fa_q && !ba_q, "relay state changed before ready")
	`ARPS_ASSERT(a_fwd_timer_live, fa_q, tmode[T_FWD] != TM_IDLE, "forward run without its timer")
	`ARPS_ASSERT_NEXT(a_ready_sticky, init_q, init_q, "ready dropped")

endmodule

FILE: rtl/core/actuator_run_pause_sequencer_core.sv
// an accepted item waits in the input register; its result is registered into the output register when it advances
// throughput: one item per cycle while results are taken, set by the single state update pass
// a waiting result stalls input only once the input register also holds an item
// reset: state to power-up values, init timer running, registers to defaults
// ----------------------------------------------------------------------------
// actuator_run_pause_sequencer_core
// six-line relay sequencer with forward/back runs, pause and manual toggles
// ----------------------------------------------------------------------------
module actuator_run_pause_sequencer_core import arps_pkg::*; #(
	parameter int TIMER_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	arps_in_if.sink    req,
	arps_out_if.source rsp,
	arps_cfg_if.sink   cfg
);

	logic [DUR_W-1:0]  init_ticks_q, run_ticks_q, pause_ticks_q;
	logic [CODE_W-1:0] fwd_code_q, back_code_q;

	logic      v_s1, v_s2;
	in_item_t  item_s1;
	out_item_t res_s2;
	logic      adv;
	out_item_t result;

	timer_mode_t            tmode [NUM_TIMERS];
	timer_cmd_t             tcmd  [NUM_TIMERS];
	logic [TIMER_WIDTH-1:0] dur   [NUM_TIMERS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ticks_q  <= RST_INIT_TICKS;
			run_ticks_q   <= RST_RUN_TICKS;
			pause_ticks_q <= RST_PAUSE_TICKS;
			fwd_code_q    <= RST_FWD_CODE;
			back_code_q   <= RST_BACK_CODE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_INIT_TICKS:        init_ticks_q  <= cfg.data;
				REG_RUN_TICKS:         run_ticks_q   <= cfg.data;
				REG_PAUSE_DELAY_TICKS: pause_ticks_q <= cfg.data;
				REG_FORWARD_CODE:      fwd_code_q    <= cfg.data[CODE_W-1:0];
				REG_BACK_CODE:         back_code_q   <= cfg.data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (rsp.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign rsp.valid = v_s2;
	assign rsp.data  = res_s2;

	assign dur[T_INIT]  = TIMER_WIDTH'(init_ticks_q);
	assign dur[T_FWD]   = TIMER_WIDTH'(run_ticks_q);
	assign dur[T_BACK]  = TIMER_WIDTH'(run_ticks_q);
	assign dur[T_PAUSE] = TIMER_WIDTH'(pause_ticks_q);

	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
		arps_timer #(
			.W        (TIMER_WIDTH),
			.RST_MODE ((g == T_INIT) ? TM_RUN : TM_IDLE)
		) u_timer (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (adv),
			.tick   (item_s1.tick),
			.cmd    (tcmd[g]),
			.dur    (dur[g]),
			.mode   (tmode[g])
		);
	end

	arps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.item         (item_s1),
		.forward_code (fwd_code_q),
		.back_code    (back_code_q),
		.tmode        (tmode),
		.tcmd         (tcmd),
		.result       (result)
	);

endmodule
